// ===== rtl/shpd_pkg.sv =====
package shpd_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_PATTERN   = 2'd0,
    CFG_MIN_PACKET_LEN = 2'd1,
    CFG_ENABLE         = 2'd2
  } cfg_idx_e;

  // register values seen by the front end
  typedef struct packed {
    logic [31:0] sync_pattern;
    logic [7:0]  min_packet_len;
    logic        enable;
  } cfg_t;

  // kind of a queue entry: one body byte or a whole buffered header
  typedef enum logic {
    ENT_BODY   = 1'b0,
    ENT_HEADER = 1'b1
  } entry_kind_e;

endpackage

// ===== rtl/shpd_if.sv =====
// input byte channel
interface shpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// recovered packet byte channel
interface shpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       packet_first;
  logic       packet_last;
  logic       run_last;

  modport source (output valid, output packet_byte, output packet_first,
                  output packet_last, output run_last, input ready);
  modport sink (input valid, input packet_byte, input packet_first,
                input packet_last, input run_last, output ready);
endinterface

// ===== rtl/shpd_front.sv =====
module shpd_front #(
  parameter int SYNC_LEN = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  shpd_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  input  logic [7:0]                 in_data,
  output logic                       in_ready,
  output logic                       push,
  output logic [8*(SYNC_LEN+1)+1:0]  push_data,
  input  logic                       q_full
);

  localparam int HDR_LEN = SYNC_LEN + 1;
  localparam int WIN_W   = 8 * HDR_LEN;
  localparam int SYNC_W  = 8 * SYNC_LEN;
  localparam int FILL_W  = $clog2(HDR_LEN + 1);
  localparam logic [7:0]        HDR_LEN_B  = 8'(HDR_LEN);
  localparam logic [FILL_W-1:0] HDR_LEN_F  = FILL_W'(HDR_LEN);
  localparam logic ENT_BODY_BIT   = logic'(shpd_pkg::ENT_BODY);
  localparam logic ENT_HEADER_BIT = logic'(shpd_pkg::ENT_HEADER);

  logic [WIN_W-1:0]  window, window_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic              in_packet, in_packet_next;
  logic [7:0]        remaining, remaining_next;

  logic [WIN_W-1:0]  shifted;
  logic [63:0]       pat_ext;
  logic [SYNC_W-1:0] sync_ref;
  logic [7:0]        len;
  logic              act;
  logic              body_last;

  // leading sync bytes beyond the register width are expected to be zero
  assign pat_ext  = {32'd0, cfg.sync_pattern};
  assign sync_ref = pat_ext[SYNC_W-1:0];

  // a disabled block drops bytes, so it never stalls the link
  assign in_ready = !cfg.enable || !q_full;
  assign act      = in_valid && in_ready && cfg.enable;

  assign shifted   = {window[WIN_W-9:0], in_data};
  assign len       = shifted[7:0];
  assign body_last = (remaining - 8'd1) == 8'd0;

  // hunting and body pass-through
  always_comb begin
    window_next    = window;
    fill_next      = fill;
    in_packet_next = in_packet;
    remaining_next = remaining;
    push           = 1'b0;
    push_data      = {ENT_BODY_BIT, 1'b0, {(WIN_W-8){1'b0}}, in_data};
    if (act) begin
      if (in_packet) begin
        remaining_next = remaining - 8'd1;
        push           = 1'b1;
        push_data      = {ENT_BODY_BIT, body_last, {(WIN_W-8){1'b0}}, in_data};
        if (body_last) begin
          in_packet_next = 1'b0;
          window_next    = '0;
          fill_next      = '0;
        end
      end else begin
        window_next = shifted;
        if (fill < HDR_LEN_F) begin
          fill_next = fill + FILL_W'(1);
        end
        if (fill_next == HDR_LEN_F && shifted[WIN_W-1:8] == sync_ref &&
            len >= cfg.min_packet_len && len >= HDR_LEN_B) begin
          push      = 1'b1;
          push_data = {ENT_HEADER_BIT, len == HDR_LEN_B, shifted};
          if (len == HDR_LEN_B) begin
            window_next = '0;
            fill_next   = '0;
          end else begin
            in_packet_next = 1'b1;
            remaining_next = len - HDR_LEN_B;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      fill      <= '0;
      in_packet <= 1'b0;
      remaining <= '0;
    end else begin
      window    <= window_next;
      fill      <= fill_next;
      in_packet <= in_packet_next;
      remaining <= remaining_next;
    end
  end

endmodule

// ===== rtl/shpd_queue.sv =====
module shpd_queue #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = count == DEPTH_C;
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/shpd_back.sv =====
module shpd_back #(
  parameter int SYNC_LEN = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [8*(SYNC_LEN+1)+1:0] q_data,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                packet_byte,
  output logic                      packet_first,
  output logic                      packet_last,
  output logic                      run_last
);

  localparam int HDR_LEN = SYNC_LEN + 1;
  localparam int WIN_W   = 8 * HDR_LEN;
  localparam int IDX_W   = $clog2(HDR_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_LEN - 1);

  logic                  cur_valid;
  shpd_pkg::entry_kind_e cur_kind;
  logic                  cur_last;
  logic [WIN_W-1:0]      cur_data;
  logic [IDX_W-1:0]      idx;

  logic             is_hdr, endh, item_done, out_fire;
  logic [IDX_W-1:0] rev;
  logic [7:0]       hdr_byte;

  // header bytes go out first byte first, from the top of the window
  assign rev      = LAST_IDX - idx;
  assign hdr_byte = cur_data[{rev, 3'b000} +: 8];

  assign is_hdr    = cur_kind == shpd_pkg::ENT_HEADER;
  assign endh      = idx == LAST_IDX;
  assign item_done = !is_hdr || endh;
  assign out_fire  = out_valid && out_ready;
  assign q_pop     = !q_empty && (!cur_valid || (out_fire && item_done));

  // output fields
  assign out_valid    = cur_valid;
  assign packet_byte  = is_hdr ? hdr_byte : cur_data[7:0];
  assign packet_first = is_hdr && idx == '0;
  assign packet_last  = is_hdr ? (endh && cur_last) : cur_last;
  assign run_last     = is_hdr ? endh : 1'b1;

  // entry occupancy and header byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (out_fire) begin
      if (item_done) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_kind <= shpd_pkg::entry_kind_e'(q_data[WIN_W+1]);
      cur_last <= q_data[WIN_W];
      cur_data <= q_data[WIN_W-1:0];
    end
  end

endmodule

// ===== rtl/sync_header_packet_deframer.sv =====
// channel   dir   payload                                          handshake
// in_ch     in    data_byte                                        valid/ready
// out_ch    out   packet_byte packet_first packet_last run_last    valid/ready
// cfg       in    cfg_index cfg_data                               cfg_we, no wait
//
// One input byte is taken per cycle while the queue has room. A matched header
// leaves as SYNC_LEN+1 output items, one per cycle from the back end while
// out_ch.ready is high; body bytes leave one each. Body bytes behind a header
// wait in the queue, and its SYNC_LEN+2 entries absorb that backlog, so
// in_ch.ready drops only while out_ch.ready is held low and the queue fills.
// Reset: registers take their reset values, window empty, queue empty.
module sync_header_packet_deframer #(
  parameter int SYNC_LEN    = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [shpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  shpd_in_if.sink                        in_ch,
  shpd_out_if.source                     out_ch
);

  localparam int ENTRY_W     = 8 * (SYNC_LEN + 1) + 2;
  localparam int QUEUE_DEPTH = SYNC_LEN + 2;

  shpd_pkg::cfg_t   cfg;
  logic             push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] push_data, q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_pattern   <= 32'd0;
      cfg.min_packet_len <= 8'd5;
      cfg.enable         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shpd_pkg::CFG_SYNC_PATTERN:   cfg.sync_pattern   <= cfg_data;
        shpd_pkg::CFG_MIN_PACKET_LEN: cfg.min_packet_len <= cfg_data[7:0];
        shpd_pkg::CFG_ENABLE:         cfg.enable         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // hunting and classification
  shpd_front #(.SYNC_LEN(SYNC_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_data   (in_ch.data_byte),
    .in_ready  (in_ch.ready),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // entry queue between front and back
  shpd_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // byte emission
  shpd_back #(.SYNC_LEN(SYNC_LEN)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_data),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .packet_byte  (out_ch.packet_byte),
    .packet_first (out_ch.packet_first),
    .packet_last  (out_ch.packet_last),
    .run_last     (out_ch.run_last)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int SYNC_LEN   = 4;
  localparam int HDR_LEN    = SYNC_LEN + 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int PRINT_CAP  = 50;

  // one recovered packet byte as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       run_end;
  } pkt_byte_t;

  logic     clk;
  logic     rst;
  logic     cfg_we;
  shpd_pkg::cfg_idx_e cfg_index;
  logic [31:0] cfg_data;

  shpd_in_if  in_ch ();
  shpd_out_if out_ch ();

  sync_header_packet_deframer #(
    .SYNC_LEN(SYNC_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // deframer state mirrored by the testbench
  logic [8*HDR_LEN-1:0] hunt_window;
  int                   hunt_fill;
  bit                   in_body;
  logic [7:0]           body_left;
  logic [31:0]          cur_sync;
  logic [7:0]           cur_min_len;
  bit                   cur_enable;

  pkt_byte_t pending_bytes[$];
  int        error_count;
  int        bytes_sent;
  int        hold_left;
  int        idle_cycles;
  bit        steady;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 21);
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // expected packet bytes caused by one accepted stream byte
  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] len;
    pkt_byte_t  r;
    int         i;
    if (!cur_enable)
      return;
    // body pass-through
    if (in_body) begin
      body_left = body_left - 8'd1;
      r = '{data: b, first: 1'b0, last: (body_left == 8'd0), run_end: 1'b1};
      pending_bytes.push_back(r);
      if (body_left == 8'd0) begin
        in_body = 1'b0;
        hunt_window = '0;
        hunt_fill = 0;
      end
      return;
    end
    // hunting: slide the window
    hunt_window = {hunt_window[8*HDR_LEN-9:0], b};
    if (hunt_fill < HDR_LEN)
      hunt_fill++;
    if (hunt_fill < HDR_LEN)
      return;
    if (hunt_window[8*HDR_LEN-1:8] != cur_sync[8*SYNC_LEN-1:0])
      return;
    len = hunt_window[7:0];
    if (len < cur_min_len || len < HDR_LEN)
      return;
    // header burst
    for (i = 0; i < HDR_LEN; i++) begin
      r.data = hunt_window[8*(HDR_LEN-i)-1 -: 8];
      r.first = (i == 0);
      r.run_end = (i == HDR_LEN - 1);
      r.last = r.run_end && (len == HDR_LEN);
      pending_bytes.push_back(r);
    end
    if (len == HDR_LEN) begin
      hunt_window = '0;
      hunt_fill = 0;
      in_body = 1'b0;
      body_left = 8'd0;
    end else begin
      in_body = 1'b1;
      body_left = len - 8'(HDR_LEN);
    end
  endfunction

  // register write, mirrored into the predictor
  task automatic write_reg(input shpd_pkg::cfg_idx_e idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      shpd_pkg::CFG_SYNC_PATTERN:   cur_sync = val;
      shpd_pkg::CFG_MIN_PACKET_LEN: cur_min_len = val[7:0];
      shpd_pkg::CFG_ENABLE:         cur_enable = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one stream byte, with a random gap before it
  task automatic send_byte(input logic [7:0] b);
    if (take_gap()) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (take_gap());
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // sync bytes, length byte, and a random body when the length is accepted
  task automatic send_frame(input logic [7:0] len);
    int i;
    for (i = 0; i < SYNC_LEN; i++)
      send_byte(cur_sync[8*(SYNC_LEN-i)-1 -: 8]);
    send_byte(len);
    if (len >= cur_min_len && len >= HDR_LEN)
      for (i = 0; i < len - HDR_LEN; i++)
        send_byte(8'($urandom_range(255)));
  endtask

  // stop offering and let every expected item drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // reset values: bytes ignored while disabled, zero sync, length rejects slide
  task automatic test_reset_values();
    int i;
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h05);
    wait_idle();
    write_reg(shpd_pkg::CFG_ENABLE, 32'd1);
    for (i = 0; i < 6; i++)
      send_byte(8'h00);
    send_byte(8'h05);
    wait_idle();
  endtask

  // header-only packet, sync mismatch, short length, body, minimum length
  task automatic test_sync_and_length();
    write_reg(shpd_pkg::CFG_SYNC_PATTERN, 32'h80FF007F);
    send_frame(8'd5);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(8'h05);
    send_frame(8'd4);
    send_frame(8'd7);
    wait_idle();
    write_reg(shpd_pkg::CFG_MIN_PACKET_LEN, 32'd10);
    send_frame(8'd9);
    send_frame(8'd10);
    wait_idle();
  endtask

  // disabling inside a packet body holds the state
  task automatic test_disable_mid_packet();
    int i;
    write_reg(shpd_pkg::CFG_MIN_PACKET_LEN, 32'd5);
    for (i = 0; i < SYNC_LEN; i++)
      send_byte(cur_sync[8*(SYNC_LEN-i)-1 -: 8]);
    send_byte(8'd9);
    send_byte(8'hA5);
    wait_idle();
    write_reg(shpd_pkg::CFG_ENABLE, 32'd0);
    for (i = 0; i < 3; i++)
      send_byte(8'($urandom_range(255)));
    wait_idle();
    write_reg(shpd_pkg::CFG_ENABLE, 32'd1);
    for (i = 0; i < 3; i++)
      send_byte(8'($urandom_range(255)));
    send_frame(8'd5);
    wait_idle();
  endtask

  // long output stall while a packet keeps coming and the queue fills
  task automatic test_output_stall();
    steady = 1'b1;
    hold_left = 80;
    send_frame(8'd14);
    steady = 1'b0;
    wait_idle();
  endtask

  // mostly well-formed frames with noise, broken syncs and bad lengths
  task automatic test_random_stream(input int n_items);
    int first_byte;
    int pick;
    int i;
    int len;
    first_byte = bytes_sent;
    steady = 1'b1;
    while (bytes_sent - first_byte < n_items) begin
      if (bytes_sent - first_byte >= n_items / 3)
        steady = 1'b0;
      pick = $urandom_range(99);
      if (pick < 15) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else if (pick < 22) begin
        for (i = 0; i < $urandom_range(1, SYNC_LEN - 1); i++)
          send_byte(cur_sync[8*(SYNC_LEN-i)-1 -: 8]);
        send_byte(8'($urandom_range(255)));
      end else if (pick < 30) begin
        send_frame(8'($urandom_range(0, cur_min_len - 1)));
      end else begin
        if ($urandom_range(9) == 0)
          len = $urandom_range(cur_min_len, cur_min_len + 30);
        else
          len = $urandom_range(cur_min_len, cur_min_len + 8);
        send_frame((len > 255) ? 8'd255 : len[7:0]);
      end
      // sender pause until the output is drained
      if ($urandom_range(19) == 0)
        wait_idle();
    end
    steady = 1'b0;
    wait_idle();
  endtask

  // largest minimum length rejects a shorter packet
  task automatic test_largest_min_len();
    write_reg(shpd_pkg::CFG_MIN_PACKET_LEN, 32'd255);
    send_frame(8'd254);
    wait_idle();
  endtask

  // output ready with random stalls and requested hold-offs
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= !take_gap();
    end
  end

  // compare each accepted item with the oldest expected one
  always @(posedge clk) begin : check_results
    pkt_byte_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected packet_byte %02h", out_ch.packet_byte));
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.packet_byte !== want.data)
          report_mismatch($sformatf("packet_byte got %02h want %02h",
                                    out_ch.packet_byte, want.data));
        if (out_ch.packet_first !== want.first)
          report_mismatch($sformatf("packet_first got %b want %b on byte %02h",
                                    out_ch.packet_first, want.first, want.data));
        if (out_ch.packet_last !== want.last)
          report_mismatch($sformatf("packet_last got %b want %b on byte %02h",
                                    out_ch.packet_last, want.last, want.data));
        if (out_ch.run_last !== want.run_end)
          report_mismatch($sformatf("run_last got %b want %b on byte %02h",
                                    out_ch.run_last, want.run_end, want.data));
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("[sync_header_packet_deframer] ERROR");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = shpd_pkg::CFG_SYNC_PATTERN;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    hunt_window = '0;
    hunt_fill = 0;
    in_body = 1'b0;
    body_left = '0;
    cur_sync = '0;
    cur_min_len = 8'd5;
    cur_enable = 1'b0;
    error_count = 0;
    bytes_sent = 0;
    hold_left = 0;
    idle_cycles = 0;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_sync_and_length();
    test_disable_mid_packet();
    test_output_stall();

    write_reg(shpd_pkg::CFG_SYNC_PATTERN, $urandom());
    write_reg(shpd_pkg::CFG_MIN_PACKET_LEN, 32'd5);
    test_random_stream(12);

    write_reg(shpd_pkg::CFG_SYNC_PATTERN, 32'hFFFFFFFF);
    write_reg(shpd_pkg::CFG_MIN_PACKET_LEN, $urandom_range(6, 12));
    test_random_stream(12);

    test_largest_min_len();

    wait_idle();
    if (error_count == 0)
      $display("[sync_header_packet_deframer] OK");
    else
      $display("[sync_header_packet_deframer] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/shpd_pkg.sv
rtl/shpd_if.sv
rtl/shpd_front.sv
rtl/shpd_queue.sv
rtl/shpd_back.sv
rtl/sync_header_packet_deframer.sv
tb/sv/testbench.sv
